// ----- sv/vad_pkg.sv -----
// Shared types, constants and correction function for the vector angle pipeline.
package vad_pkg;

   // Quotient of (small * 45) / large is 0..45, six bits
   localparam int QUOT_W = 6;
   // Quotient bits resolved per divider stage
   localparam int DIV_STEP_BITS = 2;
   localparam int NUM_DIV_STAGES = QUOT_W / DIV_STEP_BITS;
   // Result width
   localparam int ANGLE_W = 9;
   localparam int CORR_W = 3;

   localparam logic [QUOT_W-1:0] Q_SCALE = 6'd45;
   localparam logic [QUOT_W-1:0] MAX_QUOT = 6'd45;

   // Step correction thresholds
   localparam logic [QUOT_W-1:0] BAND_SPLIT = 6'd22;
   localparam logic [QUOT_W-1:0] HI_T1 = 6'd44;
   localparam logic [QUOT_W-1:0] HI_T2 = 6'd41;
   localparam logic [QUOT_W-1:0] HI_T3 = 6'd37;
   localparam logic [QUOT_W-1:0] HI_T4 = 6'd32;
   localparam logic [QUOT_W-1:0] LO_T1 = 6'd2;
   localparam logic [QUOT_W-1:0] LO_T2 = 6'd6;
   localparam logic [QUOT_W-1:0] LO_T3 = 6'd10;
   localparam logic [QUOT_W-1:0] LO_T4 = 6'd15;

   // Angle folding constants
   localparam logic [ANGLE_W-1:0] ANGLE_90 = 9'd90;
   localparam logic [ANGLE_W-1:0] ANGLE_180 = 9'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_360 = 9'd360;

   // Per-request side information carried alongside the divider data
   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic mirror;
      logic den_zero;
   } side_type;

   // Two-band step correction, 0..4
   function automatic logic [CORR_W-1:0] step_correction(input logic [QUOT_W-1:0] q);
      logic [CORR_W-1:0] c;
      c = '0;
      if (q > BAND_SPLIT) begin
         if (q <= HI_T1) c = c + 3'd1;
         if (q <= HI_T2) c = c + 3'd1;
         if (q <= HI_T3) c = c + 3'd1;
         if (q <= HI_T4) c = c + 3'd1;
      end else begin
         if (q >= LO_T1) c = c + 3'd1;
         if (q >= LO_T2) c = c + 3'd1;
         if (q >= LO_T3) c = c + 3'd1;
         if (q >= LO_T4) c = c + 3'd1;
      end
      return c;
   endfunction

endpackage

// ----- sv/vad_front.sv -----
// Front end: magnitudes, octant select, then scaling of the smaller magnitude by 45.
module vad_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic signed [COORD_BITS-1:0]              vec_x,
   input  logic signed [COORD_BITS-1:0]              vec_y,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [COORD_BITS+vad_pkg::QUOT_W-1:0]     out_prod,
   output logic [COORD_BITS-1:0]                     out_den,
   output vad_pkg::side_type                         out_side
);

   localparam int PW = COORD_BITS + vad_pkg::QUOT_W;

   logic                    a_valid_ff;
   logic [COORD_BITS-1:0]   a_num_ff;
   logic [COORD_BITS-1:0]   a_den_ff;
   vad_pkg::side_type       a_side_ff;
   logic                    b_valid_ff;
   logic [PW-1:0]           b_prod_ff;
   logic [COORD_BITS-1:0]   b_den_ff;
   vad_pkg::side_type       b_side_ff;

   logic                    a_ready;
   logic                    b_ready;
   logic [COORD_BITS-1:0]   ux;
   logic [COORD_BITS-1:0]   uy;
   logic [COORD_BITS-1:0]   ax;
   logic [COORD_BITS-1:0]   ay;
   logic [COORD_BITS-1:0]   a_num_in;
   logic [COORD_BITS-1:0]   a_den_in;
   vad_pkg::side_type       a_side_in;
   logic [PW-1:0]           b_prod_in;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // Absolute values; the most negative input maps to 2^(N-1) exactly
   assign ux = $unsigned(vec_x);
   assign uy = $unsigned(vec_y);
   assign ax = ux[COORD_BITS-1] ? (~ux + COORD_BITS'(1)) : ux;
   assign ay = uy[COORD_BITS-1] ? (~uy + COORD_BITS'(1)) : uy;

   // Smaller magnitude over larger; mirror when |x| > |y|
   always_comb begin
      a_side_in.x_neg    = ux[COORD_BITS-1];
      a_side_in.y_neg    = uy[COORD_BITS-1];
      a_side_in.mirror   = ax > ay;
      a_num_in           = a_side_in.mirror ? ay : ax;
      a_den_in           = a_side_in.mirror ? ax : ay;
      a_side_in.den_zero = (a_den_in == '0);
   end

   // Stage A control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   // Stage A payload
   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         a_num_ff  <= a_num_in;
         a_den_ff  <= a_den_in;
         a_side_ff <= a_side_in;
      end
   end

   // Dividend: smaller magnitude times 45
   assign b_prod_in = PW'(a_num_ff) * PW'(vad_pkg::Q_SCALE);

   // Stage B control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   // Stage B payload
   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_prod_ff <= b_prod_in;
         b_den_ff  <= a_den_ff;
         b_side_ff <= a_side_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_prod  = b_prod_ff;
   assign out_den   = b_den_ff;
   assign out_side  = b_side_ff;

endmodule

// ----- sv/vad_div_stage.sv -----
// One restoring-division stage resolving a pair of quotient bits.
module vad_div_stage #(
   parameter int COORD_BITS = 16,
   parameter int TOP_BIT    = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [COORD_BITS+vad_pkg::QUOT_W-1:0]  in_rem,
   input  logic [COORD_BITS-1:0]                  in_den,
   input  logic [vad_pkg::QUOT_W-1:0]             in_quot,
   input  vad_pkg::side_type                      in_side,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [COORD_BITS+vad_pkg::QUOT_W-1:0]  out_rem,
   output logic [COORD_BITS-1:0]                  out_den,
   output logic [vad_pkg::QUOT_W-1:0]             out_quot,
   output vad_pkg::side_type                      out_side
);

   localparam int PW = COORD_BITS + vad_pkg::QUOT_W;

   logic                          valid_ff;
   logic [PW-1:0]                 rem_ff;
   logic [COORD_BITS-1:0]         den_ff;
   logic [vad_pkg::QUOT_W-1:0]    quot_ff;
   vad_pkg::side_type             side_ff;

   logic                          ready;
   logic [PW-1:0]                 rem_in;
   logic [vad_pkg::QUOT_W-1:0]    quot_in;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   // Trial subtract of the shifted divisor, one quotient bit per step;
   // a zero divisor leaves the quotient at zero
   always_comb begin
      logic [PW-1:0] trial;
      rem_in  = in_rem;
      quot_in = in_quot;
      trial   = '0;
      for (int j = 0; j < vad_pkg::DIV_STEP_BITS; j++) begin
         trial = PW'(in_den) << (TOP_BIT - j);
         if (!in_side.den_zero && (rem_in >= trial)) begin
            rem_in                = rem_in - trial;
            quot_in[TOP_BIT - j]  = 1'b1;
         end
      end
   end

   // Stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quot_ff <= quot_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quot  = quot_ff;
   assign out_side  = side_ff;

endmodule

// ----- sv/vad_fold.sv -----
// Back end: step correction, mirror about 90 and quadrant fold into the output register.
module vad_fold (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [vad_pkg::QUOT_W-1:0]     in_quot,
   input  vad_pkg::side_type              in_side,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [vad_pkg::ANGLE_W-1:0]    out_angle
);

   logic                           valid_ff;
   logic [vad_pkg::ANGLE_W-1:0]    angle_ff;

   logic                           ready;
   logic [vad_pkg::ANGLE_W-1:0]    base;
   logic [vad_pkg::ANGLE_W-1:0]    octant;
   logic [vad_pkg::ANGLE_W-1:0]    angle_in;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   // Corrected first-octant angle, mirrored when |x| > |y|
   assign base   = vad_pkg::ANGLE_W'(in_quot)
                 + vad_pkg::ANGLE_W'(vad_pkg::step_correction(in_quot));
   assign octant = in_side.mirror ? (vad_pkg::ANGLE_90 - base) : base;

   // Fold by component signs
   always_comb begin
      if (in_side.y_neg) begin
         angle_in = in_side.x_neg ? (vad_pkg::ANGLE_180 + octant)
                                  : (vad_pkg::ANGLE_180 - octant);
      end else if (in_side.x_neg) begin
         angle_in = vad_pkg::ANGLE_360 - octant;
      end else begin
         angle_in = octant;
      end
   end

   // Output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_angle = angle_ff;

endmodule

// ----- sv/vector_angle_degrees_top.sv -----
// Vector angle pipeline: signed (x, y) request in, whole-degree angle 0..360 out.
//
// Request channel: req_valid with req_vec_x / req_vec_y; a request is taken on a
// rising edge with req_valid high and req_stall low. Response channel: rsp_valid
// with rsp_angle_deg, taken on an edge with rsp_valid high and rsp_stall low.
// Zero degrees lies along +y; x negative with y non-negative gives 360 - d.
// A zero vector gives 0.
//
// Pipeline stages: two front stages for magnitude select and the multiply by
// 45, three divider stages of two quotient bits each, one output register.
// Throughput: one request per cycle while rsp_stall is low, set by the fixed
// per-stage work of the divider pipeline.
//
// Reset (synchronous, active high) clears all stage valid bits; the pipeline
// is empty and ready on the next cycle. When the receiver stalls, the response
// holds and the stages fill up behind it; req_stall rises only once no stage
// can move, and no request is lost or repeated.
module vector_angle_degrees_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_BITS-1:0]       req_vec_x,
   input  logic signed [COORD_BITS-1:0]       req_vec_y,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [vad_pkg::ANGLE_W-1:0]        rsp_angle_deg
);

   localparam int PW = COORD_BITS + vad_pkg::QUOT_W;
   localparam int NS = vad_pkg::NUM_DIV_STAGES;

   logic                          front_ready;
   logic                          stg_valid [0:NS];
   logic                          stg_ready [0:NS];
   logic [PW-1:0]                 stg_rem   [0:NS];
   logic [COORD_BITS-1:0]         stg_den   [0:NS];
   logic [vad_pkg::QUOT_W-1:0]    stg_quot  [0:NS];
   vad_pkg::side_type             stg_side  [0:NS];

   assign req_stall = !front_ready;

   // Magnitudes, select and scaling
   vad_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .vec_x     (req_vec_x),
      .vec_y     (req_vec_y),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_prod  (stg_rem[0]),
      .out_den   (stg_den[0]),
      .out_side  (stg_side[0])
   );

   assign stg_quot[0] = '0;

   // Divider pipeline, most significant quotient bits first
   for (genvar s = 0; s < NS; s++) begin : g_div
      vad_div_stage #(
         .COORD_BITS (COORD_BITS),
         .TOP_BIT    (vad_pkg::QUOT_W - 1 - s * vad_pkg::DIV_STEP_BITS)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_rem    (stg_rem[s]),
         .in_den    (stg_den[s]),
         .in_quot   (stg_quot[s]),
         .in_side   (stg_side[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_rem   (stg_rem[s+1]),
         .out_den   (stg_den[s+1]),
         .out_quot  (stg_quot[s+1]),
         .out_side  (stg_side[s+1])
      );
   end

   // Correction, fold and output register
   vad_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[NS]),
      .in_ready  (stg_ready[NS]),
      .in_quot   (stg_quot[NS]),
      .in_side   (stg_side[NS]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_angle (rsp_angle_deg)
   );

   // Final quotient never exceeds 45 since the smaller magnitude is the dividend
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      stg_valid[NS] |-> (stg_quot[NS] <= vad_pkg::MAX_QUOT))
      else $error("quotient above 45");

   // Zero divisor must yield a zero quotient
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      (stg_valid[NS] && stg_side[NS].den_zero) |-> (stg_quot[NS] == '0))
      else $error("zero vector produced nonzero quotient");

   // Remainder left by the divider is below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (stg_valid[NS] && !stg_side[NS].den_zero) |-> (stg_rem[NS] < PW'(stg_den[NS])))
      else $error("divider remainder not reduced");

   // Response angle stays in range
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_deg <= vad_pkg::ANGLE_360))
      else $error("angle out of range");

   // An empty output register lets the whole pipeline move
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the vector angle pipeline (directed table plus random vectors).
`timescale 1ns / 100ps

module testbench;

   localparam int COORD_BITS = 16;
   localparam int ANGLE_W = vad_pkg::ANGLE_W;
   localparam int RANDOM_VECTORS = 500;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_PRINTED = 40;

   // One row of the directed table; angle is used only when typed is set
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         typed;
      logic [ANGLE_W-1:0]           angle;
   } vector_row_type;

   // One outstanding angle, with the vector that produced it
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [ANGLE_W-1:0]           angle;
   } pending_angle_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_vec_x = '0;
   logic signed [COORD_BITS-1:0] req_vec_y = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]           rsp_angle_deg;

   logic                         gaps_on = 1'b1;
   pending_angle_type            angle_queue[$];
   pending_angle_type            oldest;
   int                           error_count = 0;
   int                           vectors_sent = 0;
   int                           angles_checked = 0;

   // Directed vectors: zero, axes, diagonals, extremes, then each correction threshold
   vector_row_type directed_rows[25] = '{
      '{16'sd0,      16'sd0,      1'b1, 9'd0},
      '{16'sd0,      16'sd1,      1'b1, 9'd0},
      '{16'sd1,      16'sd0,      1'b1, 9'd90},
      '{16'sd0,      -16'sd1,     1'b1, 9'd180},
      '{-16'sd1,     16'sd0,      1'b1, 9'd270},
      '{16'sd1,      16'sd1,      1'b1, 9'd45},
      '{16'sd1,      -16'sd1,     1'b1, 9'd135},
      '{-16'sd1,     -16'sd1,     1'b1, 9'd225},
      '{-16'sd1,     16'sd1,      1'b1, 9'd315},
      '{16'sh8000,   16'sh8000,   1'b1, 9'd225},
      '{16'sh8000,   16'sd0,      1'b1, 9'd270},
      '{16'sd0,      16'sh8000,   1'b1, 9'd180},
      '{16'sh7fff,   16'sh7fff,   1'b1, 9'd45},
      '{16'sh7fff,   16'sh8000,   1'b0, 9'd0},
      '{16'sh8000,   16'sh7fff,   1'b0, 9'd0},
      '{16'sd2,      16'sd45,     1'b0, 9'd0},
      '{16'sd6,      16'sd45,     1'b0, 9'd0},
      '{16'sd10,     16'sd45,     1'b0, 9'd0},
      '{16'sd15,     -16'sd45,    1'b0, 9'd0},
      '{-16'sd22,    16'sd45,     1'b0, 9'd0},
      '{16'sd45,     16'sd23,     1'b0, 9'd0},
      '{-16'sd45,    -16'sd32,    1'b0, 9'd0},
      '{16'sd37,     16'sd45,     1'b0, 9'd0},
      '{16'sd41,     -16'sd45,    1'b0, 9'd0},
      '{-16'sd44,    16'sd45,     1'b0, 9'd0}
   };

   int extreme_values[6] = '{-32768, -32767, -1, 0, 1, 32767};

   vector_angle_degrees_top #(
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_vec_x(req_vec_x),
      .req_vec_y(req_vec_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_angle_deg(rsp_angle_deg)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Angle predictor: magnitudes, scaled quotient, band correction, mirror and sign fold
   function automatic logic [ANGLE_W-1:0] angle_of(input logic signed [COORD_BITS-1:0] x,
                                                   input logic signed [COORD_BITS-1:0] y);
      int unsigned mag_x, mag_y, num, den, quot, corr, deg;
      logic        mirror;
      mag_x = x[COORD_BITS-1] ? (2 ** COORD_BITS) - int'(unsigned'(x)) : int'(unsigned'(x));
      mag_y = y[COORD_BITS-1] ? (2 ** COORD_BITS) - int'(unsigned'(y)) : int'(unsigned'(y));
      mirror = mag_x > mag_y;
      num = mirror ? mag_y : mag_x;
      den = mirror ? mag_x : mag_y;
      // zero vector: quotient taken as zero
      quot = (den == 0) ? 0 : (num * 45) / den;
      // upper band counts down toward 45, lower band counts up from 0
      if (quot > 22)
         corr = int'(quot <= 44) + int'(quot <= 41) + int'(quot <= 37) + int'(quot <= 32);
      else
         corr = int'(quot >= 2) + int'(quot >= 6) + int'(quot >= 10) + int'(quot >= 15);
      deg = quot + corr;
      if (mirror) deg = 90 - deg;
      if (y[COORD_BITS-1]) begin
         deg = x[COORD_BITS-1] ? 180 + deg : 180 - deg;
      end else if (x[COORD_BITS-1]) begin
         deg = 360 - deg;
      end
      return ANGLE_W'(deg);
   endfunction

   // Magnitude up to 32767 with a random sign
   function automatic logic signed [COORD_BITS-1:0] with_random_sign(input int unsigned mag);
      return $urandom_range(1) ? COORD_BITS'(-int'(mag)) : COORD_BITS'(mag);
   endfunction

   task automatic report_mismatch(input string note);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, note);
   endtask

   // Present one request, hold it through stalls, queue its angle once taken
   task automatic push_vector(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic typed,
                              input logic [ANGLE_W-1:0] typed_angle);
      while (gaps_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= x;
      req_vec_y <= y;
      do @(posedge clock); while (req_stall);
      angle_queue.push_back(pending_angle_type'{x, y, typed ? typed_angle : angle_of(x, y)});
      vectors_sent++;
   endtask

   // Response side: random stall, and check every taken angle against the oldest one queued
   always @(posedge clock) begin
      rsp_stall <= !reset && gaps_on && ($urandom_range(99) < 17);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (angle_queue.size() == 0) begin
            report_mismatch($sformatf("angle %0d with no request outstanding", rsp_angle_deg));
         end else begin
            oldest = angle_queue.pop_front();
            angles_checked++;
            if (rsp_angle_deg !== oldest.angle)
               report_mismatch($sformatf("x=%0d y=%0d: angle %0d, want %0d",
                                         oldest.x, oldest.y, rsp_angle_deg, oldest.angle));
         end
      end
   end

   // Main sequence: reset, directed table, random vectors, drain, verdict
   initial begin
      int unsigned                  mode, big, q;
      logic signed [COORD_BITS-1:0] x, y, swap;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         push_vector(directed_rows[i].x, directed_rows[i].y,
                     directed_rows[i].typed, directed_rows[i].angle);

      for (int i = 0; i < RANDOM_VECTORS; i++) begin
         // a long stretch in the middle runs with no gaps and no stalls
         gaps_on <= !(i >= 150 && i < 260);
         mode = $urandom_range(9);
         case (mode)
            4, 5: begin
               x = with_random_sign($urandom_range(100));
               y = with_random_sign($urandom_range(100));
            end
            6: begin
               x = COORD_BITS'($urandom);
               y = '0;
               if ($urandom_range(1)) begin
                  y = x;
                  x = '0;
               end
            end
            7: begin
               // nearly equal magnitudes, around the mirror boundary
               big = $urandom_range(32764, 3);
               x = with_random_sign(big);
               y = with_random_sign(big + $urandom_range(6) - 3);
            end
            8: begin
               x = COORD_BITS'(extreme_values[$urandom_range(5)]);
               y = COORD_BITS'(extreme_values[$urandom_range(5)]);
            end
            9: begin
               // ratio aimed at a chosen quotient, exercising every correction step
               big = $urandom_range(32767, 1);
               q = $urandom_range(45);
               x = with_random_sign((big * q) / 45);
               y = with_random_sign(big);
               if ($urandom_range(1)) begin
                  swap = x;
                  x = y;
                  y = swap;
               end
            end
            default: begin
               x = COORD_BITS'($urandom);
               y = COORD_BITS'($urandom);
            end
         endcase
         push_vector(x, y, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (angle_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random vectors, %0d angles checked",
               $size(directed_rows), RANDOM_VECTORS, angles_checked);
      $display("vectors sent %0d, mismatches %0d", vectors_sent, error_count);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("timeout with %0d angles outstanding", angle_queue.size());
      $display("testbench: errors");
      $finish;
   end

endmodule

// ----- vector_angle_degrees_top.f -----
sv/vad_pkg.sv
sv/vad_front.sv
sv/vad_div_stage.sv
sv/vad_fold.sv
sv/vector_angle_degrees_top.sv
sim/testbench.sv
